[hdl/sgrde_pkg.sv]
package sgrde_pkg;

   // colour kinds
   localparam logic [1:0] KIND_DEFAULT = 2'd0;
   localparam logic [1:0] KIND_INDEX   = 2'd1;
   localparam logic [1:0] KIND_RGB     = 2'd2;

   // SGR codes
   localparam logic [7:0] SGR_RESET    = 8'd0;
   localparam logic [7:0] SGR_NORMAL   = 8'd22;
   localparam logic [7:0] SGR_CLR_BASE = 8'd20;
   localparam logic [7:0] FG_DEFAULT   = 8'd39;
   localparam logic [7:0] BG_DEFAULT   = 8'd49;
   localparam logic [7:0] FG_BASE      = 8'd30;
   localparam logic [7:0] BG_BASE      = 8'd40;
   localparam logic [7:0] FG_BRIGHT    = 8'd90;
   localparam logic [7:0] BG_BRIGHT    = 8'd100;
   localparam logic [7:0] FG_EXT       = 8'd38;
   localparam logic [7:0] BG_EXT       = 8'd48;
   localparam logic [7:0] SUB_INDEX    = 8'd5;
   localparam logic [7:0] SUB_RGB      = 8'd2;

   localparam int ATTR_W = 9;
   localparam int MAX_SUB = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] idx;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } colour_type;

   // one primary with its sub-parameters, as queued between front and back
   typedef struct packed {
      logic [7:0]               value;
      logic                     opens;
      logic                     close;
      logic [2:0]               nsub;
      logic [MAX_SUB-1:0][7:0]  sub;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[hdl/sgrde_queue.sv]
module sgrde_queue #(
   parameter int DEPTH = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sgrde_pkg::entry_type wdata,
   input  logic                 pop,
   output sgrde_pkg::entry_type rdata,
   output sgrde_pkg::qstat_type stat
);
   import sgrde_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

[hdl/sgrde_front.sv]
module sgrde_front #(
   parameter int LOAD_LIMIT = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_push,
   output logic                  in_full,
   input  logic [8:0]            in_attr,
   input  sgrde_pkg::colour_type in_fg,
   input  sgrde_pkg::colour_type in_bg,
   output logic                  q_push,
   output sgrde_pkg::entry_type  q_wdata,
   input  sgrde_pkg::qstat_type  q_stat
);
   import sgrde_pkg::*;

   localparam int LW = $clog2(LOAD_LIMIT + 6);

   // scan steps: reset code, attributes 1..9, fg, bg, flush
   localparam logic [3:0] STEP_RESET = 4'd0;
   localparam logic [3:0] STEP_ATTR1 = 4'd1;
   localparam logic [3:0] STEP_ATTR9 = 4'd9;
   localparam logic [3:0] STEP_FG    = 4'd10;
   localparam logic [3:0] STEP_BG    = 4'd11;

   function automatic entry_type colour_entry(colour_type c, logic fg);
      entry_type e;
      e = '0;
      case (c.kind)
         KIND_INDEX: begin
            if (c.idx < 8'd8) begin
               e.value = (fg ? FG_BASE : BG_BASE) + {5'b0, c.idx[2:0]};
            end else if (c.idx < 8'd16) begin
               e.value = (fg ? FG_BRIGHT : BG_BRIGHT) + {5'b0, c.idx[2:0]};
            end else begin
               e.value  = fg ? FG_EXT : BG_EXT;
               e.nsub   = 3'd2;
               e.sub[0] = SUB_INDEX;
               e.sub[1] = c.idx;
            end
         end
         KIND_RGB: begin
            e.value  = fg ? FG_EXT : BG_EXT;
            e.nsub   = 3'd4;
            e.sub[0] = SUB_RGB;
            e.sub[1] = c.r;
            e.sub[2] = c.g;
            e.sub[3] = c.b;
         end
         default: begin
            e.value = fg ? FG_DEFAULT : BG_DEFAULT;
         end
      endcase
      return e;
   endfunction

   logic             busy_ff, busy_in;
   logic [3:0]       step_ff, step_in;
   logic             zero_ff, zero_in;
   logic [8:0]       chg_ff, chg_in;
   logic [8:0]       attr_ff, attr_in;
   logic             fgc_ff, fgc_in;
   logic             bgc_ff, bgc_in;
   colour_type       fg_ff, fg_in;
   colour_type       bg_ff, bg_in;
   logic [8:0]       prev_attr_ff, prev_attr_in;
   colour_type       prev_fg_ff, prev_fg_in;
   colour_type       prev_bg_ff, prev_bg_in;
   logic [LW-1:0]    load_ff, load_in;
   logic             first_ff, first_in;
   entry_type        pend_ff, pend_in;
   logic             pend_v_ff, pend_v_in;

   logic             have;
   entry_type        cand;
   logic [3:0]       aidx;
   logic [LW-1:0]    prim_load, sum;
   logic             split, zero_now;
   colour_type       base_fg, base_bg;

   assign in_full = busy_ff;
   assign aidx    = step_ff - STEP_ATTR1;

   always_comb begin
      have = 1'b0;
      cand = '0;
      case (step_ff) inside
         STEP_RESET: begin
            have       = zero_ff;
            cand.value = SGR_RESET;
         end
         [STEP_ATTR1:STEP_ATTR9]: begin
            have = chg_ff[aidx];
            if (attr_ff[aidx]) begin
               cand.value = {4'b0, step_ff};
            end else if (step_ff == STEP_ATTR1) begin
               cand.value = SGR_NORMAL;
            end else begin
               cand.value = SGR_CLR_BASE + {4'b0, step_ff};
            end
         end
         STEP_FG: begin
            have = fgc_ff;
            cand = colour_entry(fg_ff, 1'b1);
         end
         STEP_BG: begin
            have = bgc_ff;
            cand = colour_entry(bg_ff, 1'b0);
         end
         default: begin
            have = 1'b0;
         end
      endcase
   end

   assign prim_load = LW'(1) + LW'(cand.nsub);
   assign sum       = load_ff + prim_load;
   assign split     = (load_ff != '0) && (sum > LW'(LOAD_LIMIT));

   // change detection against the remembered style
   assign zero_now = (in_attr == '0) && (prev_attr_ff != '0);
   assign base_fg  = zero_now ? colour_type'('0) : prev_fg_ff;
   assign base_bg  = zero_now ? colour_type'('0) : prev_bg_ff;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      zero_in      = zero_ff;
      chg_in       = chg_ff;
      attr_in      = attr_ff;
      fgc_in       = fgc_ff;
      bgc_in       = bgc_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      prev_attr_in = prev_attr_ff;
      prev_fg_in   = prev_fg_ff;
      prev_bg_in   = prev_bg_ff;
      load_in      = load_ff;
      first_in     = first_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      q_push       = 1'b0;
      q_wdata      = pend_ff;

      if (!busy_ff) begin
         if (in_push) begin
            busy_in      = 1'b1;
            step_in      = STEP_RESET;
            zero_in      = zero_now;
            chg_in       = (in_attr != '0) ? (in_attr ^ prev_attr_ff) : '0;
            attr_in      = in_attr;
            fgc_in       = (in_fg != base_fg);
            bgc_in       = (in_bg != base_bg);
            fg_in        = in_fg;
            bg_in        = in_bg;
            prev_attr_in = in_attr;
            prev_fg_in   = in_fg;
            prev_bg_in   = in_bg;
            load_in      = '0;
            first_in     = 1'b1;
            pend_v_in    = 1'b0;
         end
      end else if (step_ff > STEP_BG) begin
         // flush: held primary closes the item's last sequence
         q_wdata.close = 1'b1;
         if (!pend_v_ff) begin
            busy_in = 1'b0;
         end else if (!q_stat.full) begin
            q_push    = 1'b1;
            pend_v_in = 1'b0;
            busy_in   = 1'b0;
         end
      end else if (!have) begin
         step_in = step_ff + 4'd1;
      end else if (!(pend_v_ff && q_stat.full)) begin
         // held primary learns whether a split follows it
         q_wdata.close = split;
         q_push        = pend_v_ff;
         pend_in       = cand;
         pend_in.opens = first_ff || split;
         pend_v_in     = 1'b1;
         load_in       = split ? prim_load : sum;
         first_in      = 1'b0;
         step_in       = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_RESET;
         pend_v_ff    <= 1'b0;
         prev_attr_ff <= '0;
         prev_fg_ff   <= '0;
         prev_bg_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         pend_v_ff    <= pend_v_in;
         prev_attr_ff <= prev_attr_in;
         prev_fg_ff   <= prev_fg_in;
         prev_bg_ff   <= prev_bg_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff  <= zero_in;
      chg_ff   <= chg_in;
      attr_ff  <= attr_in;
      fgc_ff   <= fgc_in;
      bgc_ff   <= bgc_in;
      fg_ff    <= fg_in;
      bg_ff    <= bg_in;
      load_ff  <= load_in;
      first_ff <= first_in;
      pend_ff  <= pend_in;
   end

endmodule

[hdl/sgrde_back.sv]
module sgrde_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sgrde_pkg::entry_type q_rdata,
   input  sgrde_pkg::qstat_type q_stat,
   output logic                 q_pop,
   output logic                 out_empty,
   input  logic                 out_pop,
   output logic [7:0]           out_value,
   output logic                 out_opens,
   output logic                 out_is_sub,
   output logic                 out_last
);
   import sgrde_pkg::*;

   logic        out_v_ff, out_v_in;
   logic [2:0]  sub_ff, sub_in;
   logic [7:0]  value_ff, value_in;
   logic        opens_ff, opens_in;
   logic        is_sub_ff, is_sub_in;
   logic        last_ff, last_in;
   logic        load_word, entry_done;
   logic [1:0]  sidx;

   assign out_empty  = !out_v_ff;
   assign out_value  = value_ff;
   assign out_opens  = opens_ff;
   assign out_is_sub = is_sub_ff;
   assign out_last   = last_ff;

   assign load_word  = (!out_v_ff || out_pop) && !q_stat.empty;
   assign sidx       = 2'(sub_ff - 3'd1);
   assign entry_done = (sub_ff == q_rdata.nsub);
   assign q_pop      = load_word && entry_done;

   always_comb begin
      out_v_in  = out_v_ff;
      sub_in    = sub_ff;
      value_in  = value_ff;
      opens_in  = opens_ff;
      is_sub_in = is_sub_ff;
      last_in   = last_ff;
      if (load_word) begin
         out_v_in = 1'b1;
         if (sub_ff == '0) begin
            value_in  = q_rdata.value;
            opens_in  = q_rdata.opens;
            is_sub_in = 1'b0;
         end else begin
            value_in  = q_rdata.sub[sidx];
            opens_in  = 1'b0;
            is_sub_in = 1'b1;
         end
         last_in = q_rdata.close && entry_done;
         sub_in  = entry_done ? 3'd0 : sub_ff + 3'd1;
      end else if (out_pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         out_v_ff <= out_v_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      opens_ff  <= opens_in;
      is_sub_ff <= is_sub_in;
      last_ff   <= last_in;
   end

endmodule

[hdl/sgr_style_delta_encoder.sv]
// SGR style delta encoder.
// Input queue side: drive req_* style fields and raise req_push; a word is
// taken on a clock edge with req_push high and req_full low. Each word is one
// cell style (attribute mask, fg and bg colours).
// Result queue side: while rsp_empty is low the oldest SGR parameter number
// sits on rsp_*; raise rsp_pop to take it. Flags mark ESC [ openings,
// sub-parameters of 38/48 and the final number before m.
// Flow: the front scans one candidate code per cycle while the primary queue
// has room (reset code, nine attributes, fg, bg) plus a flush step, and
// holds req_full high from acceptance until the flush, so it takes no new
// style word before its scan of the current one ends. The back emits one
// parameter word per cycle while rsp_pop is high and the queue holds primaries,
// up to 19 per style. The front holds each primary until it knows whether a
// split follows. Sustained rate per style is set by the front scan loop and
// the single output register.
// Reset: remembered style returns to no attributes and default colours,
// the primary queue and output register empty.
// Stall: if rsp_pop stays low the primary queue (PARAM_SLOTS deep) fills,
// the front halts mid-scan and req_full stays high; nothing is dropped.
module sgr_style_delta_encoder #(
   parameter int LOAD_LIMIT  = 10,
   parameter int PARAM_SLOTS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [8:0]  req_attr_mask,
   input  logic [1:0]  req_fg_kind,
   input  logic [7:0]  req_fg_index,
   input  logic [7:0]  req_fg_red,
   input  logic [7:0]  req_fg_green,
   input  logic [7:0]  req_fg_blue,
   input  logic [1:0]  req_bg_kind,
   input  logic [7:0]  req_bg_index,
   input  logic [7:0]  req_bg_red,
   input  logic [7:0]  req_bg_green,
   input  logic [7:0]  req_bg_blue,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_param_value,
   output logic        rsp_opens_sequence,
   output logic        rsp_is_sub,
   output logic        rsp_last
);
   import sgrde_pkg::*;

   colour_type fg_norm, bg_norm;
   logic       q_push, q_pop;
   entry_type  q_wdata, q_rdata;
   qstat_type  q_stat;

   // Normalize colours: kind 3 reads as default, unused fields zeroed so
   // the front can compare whole structs.
   always_comb begin
      fg_norm = '0;
      case (req_fg_kind)
         KIND_INDEX: begin
            fg_norm.kind = KIND_INDEX;
            fg_norm.idx  = req_fg_index;
         end
         KIND_RGB: begin
            fg_norm.kind = KIND_RGB;
            fg_norm.r    = req_fg_red;
            fg_norm.g    = req_fg_green;
            fg_norm.b    = req_fg_blue;
         end
         default: fg_norm = '0;
      endcase
   end

   always_comb begin
      bg_norm = '0;
      case (req_bg_kind)
         KIND_INDEX: begin
            bg_norm.kind = KIND_INDEX;
            bg_norm.idx  = req_bg_index;
         end
         KIND_RGB: begin
            bg_norm.kind = KIND_RGB;
            bg_norm.r    = req_bg_red;
            bg_norm.g    = req_bg_green;
            bg_norm.b    = req_bg_blue;
         end
         default: bg_norm = '0;
      endcase
   end

   // front: change detection, code selection, sequence splitting
   sgrde_front #(
      .LOAD_LIMIT (LOAD_LIMIT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_push (req_push),
      .in_full (req_full),
      .in_attr (req_attr_mask),
      .in_fg   (fg_norm),
      .in_bg   (bg_norm),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_stat  (q_stat)
   );

   // primaries waiting for the back end
   sgrde_queue #(
      .DEPTH (PARAM_SLOTS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // back: expands each primary into its words
   sgrde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rdata    (q_rdata),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_value  (rsp_param_value),
      .out_opens  (rsp_opens_sequence),
      .out_is_sub (rsp_is_sub),
      .out_last   (rsp_last)
   );

endmodule
